// File: src/assert_macros.svh
// Assertion macros shared by the chunk framer RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_IMPLY(label, cond, conseq, msg) \
	`ASSERT_CLK(label, (cond) |-> (conseq), msg)

`define ASSERT_NEXT(label, cond, conseq, msg) \
	`ASSERT_CLK(label, (cond) |=> (conseq), msg)

`endif

// File: src/pcf_pkg.sv
// Package of the PNG chunk framer: item and burst types, constants and the CRC byte step.
// No dependencies; the input register, control, emitter and top-level files use it.
package pcf_pkg;

	localparam logic [31:0] CRC_POLY_REFLECTED = 32'hedb88320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hffffffff;

	localparam int LEN_W = 31;
	localparam int TYPE_W = 32;
	localparam int BYTE_W = 8;
	localparam int CNT_W = 4;
	localparam int FEED_W = 3;

	localparam logic [CNT_W-1:0] BURST_ERR = 4'd1;
	localparam logic [CNT_W-1:0] BURST_DATA = 4'd1;
	localparam logic [CNT_W-1:0] BURST_DATA_LAST = 4'd5;
	localparam logic [CNT_W-1:0] BURST_HDR = 4'd8;
	localparam logic [CNT_W-1:0] BURST_HDR_EMPTY = 4'd12;
	localparam logic [CNT_W-1:0] CRC_BYTES = 4'd4;
	localparam logic [FEED_W-1:0] FEED_BYTES = 3'd4;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA = 1'b1
	} cmd_t;

	typedef struct packed {
		logic command;
		logic [TYPE_W-1:0] chunk_type;
		logic [LEN_W-1:0] chunk_length;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic load;
		logic [63:0] bytes;
		logic [CNT_W-1:0] count;
		logic crc_tail;
		logic err;
	} burst_t;

	typedef struct packed {
		logic feed_busy;
		logic chunk_open;
	} ctrl_status_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
		input logic [BYTE_W-1:0] b);
		logic [31:0] c;
		int i;
		c = crc_in ^ {24'd0, b};
		for (i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: src/pcf_chan_if.sv
// Channel interfaces of the PNG chunk framer: the command input and the byte output.
// Depends on nothing; the payload fields are plain signals.
interface pcf_item_if;
	logic valid;
	logic ready;
	logic command;
	logic [31:0] chunk_type;
	logic [30:0] chunk_length;
	logic [7:0] data_byte;

	modport source(output valid, command, chunk_type, chunk_length, data_byte, input ready);
	modport sink(input valid, command, chunk_type, chunk_length, data_byte, output ready);
endinterface

interface pcf_result_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic chunk_done;
	logic seq_error;

	modport source(output valid, out_byte, chunk_done, seq_error, input ready);
	modport sink(input valid, out_byte, chunk_done, seq_error, output ready);
endinterface

// File: src/pcf_in_reg.sv
// Input register stage of the PNG chunk framer.
// Depends on pcf_pkg and pcf_item_if.
module pcf_in_reg (
	input logic clk,
	input logic arst_n,
	pcf_item_if.sink items,
	input logic advance,
	output logic valid_s1,
	output pcf_pkg::item_t item_s1
);

	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.command <= items.command;
			item_s1.chunk_type <= items.chunk_type;
			item_s1.chunk_length <= items.chunk_length;
			item_s1.data_byte <= items.data_byte;
		end
	end

endmodule

// File: src/pcf_ctrl.sv
// Chunk control of the PNG chunk framer: sequence check, length count and running CRC.
// Depends on pcf_pkg; feeds one burst description per transaction to the emitter.
module pcf_ctrl (
	input logic clk,
	input logic arst_n,
	input logic valid_s1,
	input pcf_pkg::item_t item_s1,
	input logic emit_free,
	output logic advance,
	output pcf_pkg::burst_t burst,
	output logic [31:0] crc,
	output pcf_pkg::ctrl_status_t status
);

	logic [31:0] crc_q, crc_d;
	logic [pcf_pkg::LEN_W-1:0] left_q, left_d;
	logic open_q, open_d;
	logic [31:0] feed_q, feed_d;
	logic [pcf_pkg::FEED_W-1:0] feed_cnt_q, feed_cnt_d;
	logic is_start;
	logic empty;
	logic last;

	assign advance = valid_s1 && emit_free;
	assign is_start = pcf_pkg::cmd_t'(item_s1.command) == pcf_pkg::CMD_START;
	assign empty = item_s1.chunk_length == '0;
	assign last = left_q == {{(pcf_pkg::LEN_W-1){1'b0}}, 1'b1};

	// The type tag enters the CRC one byte a cycle, while the header bytes go out.
	always_comb begin
		crc_d = crc_q;
		left_d = left_q;
		open_d = open_q;
		feed_d = feed_q;
		feed_cnt_d = feed_cnt_q;
		burst = '0;
		burst.load = advance;
		if (feed_cnt_q != '0) begin
			crc_d = pcf_pkg::crc_byte(crc_q, feed_q[31:24]);
			feed_d = {feed_q[23:0], 8'd0};
			feed_cnt_d = feed_cnt_q - 1'b1;
		end
		if (advance) begin
			if (is_start == open_q) begin
				burst.count = pcf_pkg::BURST_ERR;
				burst.err = 1'b1;
			end else if (is_start) begin
				burst.bytes = {1'b0, item_s1.chunk_length, item_s1.chunk_type};
				burst.count = empty ? pcf_pkg::BURST_HDR_EMPTY : pcf_pkg::BURST_HDR;
				burst.crc_tail = empty;
				open_d = !empty;
				left_d = item_s1.chunk_length;
				crc_d = pcf_pkg::CRC_ALL_ONES;
				feed_d = item_s1.chunk_type;
				feed_cnt_d = pcf_pkg::FEED_BYTES;
			end else begin
				burst.bytes = {item_s1.data_byte, 56'd0};
				burst.count = last ? pcf_pkg::BURST_DATA_LAST : pcf_pkg::BURST_DATA;
				burst.crc_tail = last;
				open_d = !last;
				left_d = left_q - 1'b1;
				crc_d = pcf_pkg::crc_byte(crc_q, item_s1.data_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= pcf_pkg::CRC_ALL_ONES;
			left_q <= '0;
			open_q <= 1'b0;
			feed_cnt_q <= '0;
		end else begin
			crc_q <= crc_d;
			left_q <= left_d;
			open_q <= open_d;
			feed_cnt_q <= feed_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		feed_q <= feed_d;
	end

	assign crc = crc_q;
	assign status.feed_busy = feed_cnt_q != '0;
	assign status.chunk_open = open_q;

endmodule

// File: src/pcf_emit.sv
// Byte emitter of the PNG chunk framer: shifts out one burst and appends the inverted CRC when it ends a chunk.
// Depends on pcf_pkg and pcf_result_if.
module pcf_emit (
	input logic clk,
	input logic arst_n,
	input pcf_pkg::burst_t burst,
	input logic [31:0] crc,
	pcf_result_if.source results,
	output logic emit_free
);

	logic [pcf_pkg::CNT_W-1:0] cnt_q;
	logic tail_q;
	logic err_q;
	logic [63:0] bytes_q;
	logic take;
	logic [31:0] fin;
	logic [7:0] crc_sel;
	logic in_tail;

	assign take = results.valid && results.ready;
	assign emit_free = (cnt_q == '0) ||
		((cnt_q == {{(pcf_pkg::CNT_W-1){1'b0}}, 1'b1}) && results.ready);
	assign fin = ~crc;
	assign in_tail = tail_q && (cnt_q <= pcf_pkg::CRC_BYTES);

	always_comb begin
		case (cnt_q[2:0])
			3'd4: crc_sel = fin[31:24];
			3'd3: crc_sel = fin[23:16];
			3'd2: crc_sel = fin[15:8];
			default: crc_sel = fin[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			tail_q <= 1'b0;
			err_q <= 1'b0;
		end else if (burst.load) begin
			cnt_q <= burst.count;
			tail_q <= burst.crc_tail;
			err_q <= burst.err;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (burst.load) begin
			bytes_q <= burst.bytes;
		end else if (take) begin
			bytes_q <= {bytes_q[55:0], 8'd0};
		end
	end

	assign results.valid = cnt_q != '0;
	assign results.out_byte = in_tail ? crc_sel : bytes_q[63:56];
	assign results.chunk_done = tail_q && (cnt_q == {{(pcf_pkg::CNT_W-1){1'b0}}, 1'b1});
	assign results.seq_error = err_q;

endmodule

// File: src/png_chunk_framer_crc32.sv
// Top level of the PNG chunk framer with CRC-32.
// Depends on pcf_pkg, the channel interfaces, the three stage modules and assert_macros.svh.
//
//   channel   dir  transaction
//   items     in   start (type, length) or one payload byte
//   results   out  one byte of the framed stream, with end and error flags
//
// A transaction in the input register is handled once the emitter is free.
// It yields 1, 5, 8 or 12 output bytes, one per cycle while results is ready, so payload bytes
// pass at that rate. The type tag enters the CRC byte by byte behind the eight header bytes.
// Reset is asynchronous; no clearing pass is needed.
// A stall at the output holds the emitter and, once the input register is full, the input.
`include "assert_macros.svh"

module png_chunk_framer_crc32 (
	input logic clk,
	input logic arst_n,
	pcf_item_if.sink items,
	pcf_result_if.source results
);

	logic valid_s1;
	pcf_pkg::item_t item_s1;
	logic advance;
	logic emit_free;
	pcf_pkg::burst_t burst;
	logic [31:0] crc;
	pcf_pkg::ctrl_status_t status;

	pcf_in_reg u_in_reg (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.advance(advance),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	pcf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.item_s1(item_s1),
		.emit_free(emit_free),
		.advance(advance),
		.burst(burst),
		.crc(crc),
		.status(status)
	);

	pcf_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.burst(burst),
		.crc(crc),
		.results(results),
		.emit_free(emit_free)
	);

	`ASSERT_IMPLY(a_load_when_free, burst.load, emit_free, "burst loaded into a busy emitter")
	`ASSERT_IMPLY(a_feed_hidden, status.feed_busy, results.valid, "CRC feed outlived header")
	`ASSERT_NEXT(a_tail_closes, burst.load && burst.crc_tail, !status.chunk_open, "chunk left open")
	`ASSERT_IMPLY(a_done_clean, results.chunk_done, results.valid && !results.seq_error, "end on error")

endmodule
